### src/mhih_pkg.sv
// Shared constants and the CORDIC arctangent table for the hard-iron heading block.
package mhih_pkg;

  // Angle format: degrees with 16 fraction bits
  localparam int FRAC_BITS = 16;
  localparam int ANG_W     = 25;
  localparam int DEG_W     = 9;
  localparam int TAB_LEN   = 24;
  localparam int TAB_IDX_W = 5;

  localparam logic [ANG_W-1:0] DEG90_Q  = ANG_W'(90  << FRAC_BITS);
  localparam logic [ANG_W-1:0] DEG180_Q = ANG_W'(180 << FRAC_BITS);
  localparam logic [ANG_W-1:0] DEG360_Q = ANG_W'(360 << FRAC_BITS);

  localparam logic [DEG_W-1:0] HEAD_0   = DEG_W'(0);
  localparam logic [DEG_W-1:0] HEAD_90  = DEG_W'(90);
  localparam logic [DEG_W-1:0] HEAD_270 = DEG_W'(270);
  localparam logic [DEG_W-1:0] HEAD_360 = DEG_W'(360);

  // atan(2^-i) in degrees, Q.16, rounded to nearest
  function automatic logic [ANG_W-1:0] atan_q16(input logic [TAB_IDX_W-1:0] idx);
    logic [ANG_W-1:0] v;
    unique case (idx)
      5'd0:    v = ANG_W'(2949120);
      5'd1:    v = ANG_W'(1740967);
      5'd2:    v = ANG_W'(919879);
      5'd3:    v = ANG_W'(466945);
      5'd4:    v = ANG_W'(234379);
      5'd5:    v = ANG_W'(117304);
      5'd6:    v = ANG_W'(58666);
      5'd7:    v = ANG_W'(29335);
      5'd8:    v = ANG_W'(14668);
      5'd9:    v = ANG_W'(7334);
      5'd10:   v = ANG_W'(3667);
      5'd11:   v = ANG_W'(1833);
      5'd12:   v = ANG_W'(917);
      5'd13:   v = ANG_W'(458);
      5'd14:   v = ANG_W'(229);
      5'd15:   v = ANG_W'(115);
      5'd16:   v = ANG_W'(57);
      5'd17:   v = ANG_W'(29);
      5'd18:   v = ANG_W'(14);
      5'd19:   v = ANG_W'(7);
      5'd20:   v = ANG_W'(4);
      5'd21:   v = ANG_W'(2);
      5'd22:   v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### src/magnetometer_hard_iron_heading.sv
// Hard-iron min/max calibration and CORDIC compass heading, top level.
//
// Channel | Dir | Signals                   | Contents
// --------+-----+---------------------------+-------------------------------------------
// s       | in  | s_tvalid s_tready s_tdata | raw sample: mag_x, mag_y, mag_z
// m       | out | m_tvalid m_tready m_tdata | cal_x, cal_y, cal_z, heading_deg
//
// A sample passes from accept to the next accept through the accept step, the setup
// steps (update, offset, correction, prep), N passes of the shared shift/add CORDIC
// unit (N being min(CORDIC_ITERATIONS, 24)), a clamp step and a quadrant-mapping step.
// A zero corrected X or Y skips the CORDIC passes.
// s_tready is high only while the sequencer is idle. A result sits in the
// output register until taken; a stalled output holds the sequencer in its last step.
// rst is synchronous and clears the running max/min/offset of each axis to zero.
module magnetometer_hard_iron_heading #(
  parameter int SAMPLE_WIDTH      = 16,
  parameter int CORDIC_ITERATIONS = 16,
  localparam int S_TDATA_W = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int M_TDATA_W = ((3 * SAMPLE_WIDTH + 9 + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // mag_x, mag_y, mag_z, zero pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // cal_x, cal_y, cal_z, heading_deg, zero pad
);

  import mhih_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int XW     = SAMPLE_WIDTH + 3;
  localparam int N_ITER = (CORDIC_ITERATIONS < TAB_LEN) ? CORDIC_ITERATIONS : TAB_LEN;
  localparam int CW     = (N_ITER > 1) ? $clog2(N_ITER) : 1;
  localparam int OUT_W  = 3 * SW + DEG_W;
  localparam logic [CW-1:0] LAST_ITER = CW'(N_ITER - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_UPD, ST_OFS, ST_CAL, ST_PREP, ST_ITER, ST_CLAMP, ST_HEAD
  } state_t;

  state_t state;

  // Per-axis calibration state and working values
  logic signed [SW-1:0] axis_maximum [3];
  logic signed [SW-1:0] axis_minimum [3];
  logic signed [SW-1:0] axis_offset  [3];
  logic signed [SW-1:0] smp          [3];
  logic signed [SW-1:0] cal_val      [3];
  logic        [2:0]    upd;

  // CORDIC working registers
  logic signed [XW-1:0]    cx;
  logic signed [XW-1:0]    cy;
  logic signed [ANG_W-1:0] cz;
  logic        [CW-1:0]    cnt;
  logic                    x_zero;
  logic                    x_neg;
  logic                    y_zero;
  logic                    y_neg;

  logic signed [XW-1:0]    dx;
  logic signed [XW-1:0]    dy;
  logic signed [ANG_W-1:0] step_ang;
  logic                    cy_pos;
  logic signed [XW-1:0]    abs_x;
  logic signed [XW-1:0]    abs_y;
  logic        [ANG_W-1:0] t_ang;
  logic        [DEG_W-1:0] t_deg;
  logic        [DEG_W-1:0] heading;
  logic                    out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Shared CORDIC step: barrel shift, table lookup, direction
  assign dx       = cy >>> cnt;
  assign dy       = cx >>> cnt;
  assign step_ang = signed'(atan_q16(TAB_IDX_W'(cnt)));
  assign cy_pos   = !cy[XW-1] && (cy != '0);

  // Magnitudes of the corrected X and Y
  always_comb begin
    abs_x = XW'(cal_val[0]);
    abs_y = XW'(cal_val[1]);
    if (cal_val[0][SW-1]) begin
      abs_x = -abs_x;
    end
    if (cal_val[1][SW-1]) begin
      abs_y = -abs_y;
    end
  end

  // Quadrant mapping and wrap into 0..359
  always_comb begin
    if (!x_neg) begin
      t_ang = y_neg ? (DEG360_Q - cz) : ANG_W'(cz);
    end else begin
      t_ang = (y_neg || y_zero) ? (DEG180_Q + cz) : (DEG180_Q - cz);
    end
    t_deg = t_ang[ANG_W-1:FRAC_BITS];
    if (x_zero) begin
      heading = y_zero ? HEAD_0 : (y_neg ? HEAD_270 : HEAD_90);
    end else if (t_deg >= HEAD_360) begin
      heading = t_deg - HEAD_360;
    end else begin
      heading = t_deg;
    end
  end

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    logic signed [SW:0] sum;
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        axis_maximum[k] <= '0;
        axis_minimum[k] <= '0;
        axis_offset[k]  <= '0;
      end
    end else begin
      // Output drains unless a new result is loaded in the same cycle
      if (m_tvalid && m_tready && (state != ST_HEAD)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            for (int k = 0; k < 3; k++) begin
              smp[k] <= s_tdata[k*SW +: SW];
            end
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          for (int k = 0; k < 3; k++) begin
            upd[k] <= (axis_maximum[k] < smp[k]) || (axis_minimum[k] > smp[k]);
            if (axis_maximum[k] < smp[k]) begin
              axis_maximum[k] <= smp[k];
            end else if (axis_minimum[k] > smp[k]) begin
              axis_minimum[k] <= smp[k];
            end
          end
          state <= ST_OFS;
        end
        ST_OFS: begin
          for (int k = 0; k < 3; k++) begin
            sum = (SW+1)'(axis_maximum[k]) + (SW+1)'(axis_minimum[k]);
            if (upd[k]) begin
              axis_offset[k] <= sum[SW:1];
            end
          end
          state <= ST_CAL;
        end
        ST_CAL: begin
          for (int k = 0; k < 3; k++) begin
            cal_val[k] <= smp[k] - axis_offset[k];
          end
          state <= ST_PREP;
        end
        ST_PREP: begin
          x_zero <= (cal_val[0] == '0);
          x_neg  <= cal_val[0][SW-1];
          y_zero <= (cal_val[1] == '0);
          y_neg  <= cal_val[1][SW-1];
          cx     <= abs_x;
          cy     <= abs_y;
          cz     <= '0;
          cnt    <= '0;
          if ((cal_val[0] == '0) || (cal_val[1] == '0)) begin
            state <= ST_CLAMP;
          end else begin
            state <= ST_ITER;
          end
        end
        ST_ITER: begin
          if (cy_pos) begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + step_ang;
          end else begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - step_ang;
          end
          cnt <= cnt + CW'(1);
          if (cnt == LAST_ITER) begin
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          if (cz < 0) begin
            cz <= '0;
          end else if (cz > signed'(DEG90_Q)) begin
            cz <= signed'(DEG90_Q);
          end
          state <= ST_HEAD;
        end
        ST_HEAD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= M_TDATA_W'({heading, cal_val[2], cal_val[1], cal_val[0]});
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Running extremes keep min <= max on every axis
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (axis_minimum[0] <= axis_maximum[0]) && (axis_minimum[1] <= axis_maximum[1]) &&
    (axis_minimum[2] <= axis_maximum[2]))
    else $error("axis minimum above maximum");

  // Iteration count stays inside the table
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ITER) |-> (cnt <= LAST_ITER))
    else $error("CORDIC counter out of range");

  // First-quadrant angle is clamped before mapping
  a_clamped: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HEAD) |-> ((cz >= 0) && (cz <= signed'(DEG90_Q))))
    else $error("angle not clamped");

  // Reported heading stays below 360
  a_heading: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_W-1 -: DEG_W] < HEAD_360))
    else $error("heading out of range");

  // An accepted sample starts the update step
  a_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_UPD))
    else $error("sequencer did not start");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the hard-iron calibration and compass heading block.
`timescale 1ns / 1ps

module tb_top;
  import mhih_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int CORDIC_N = 16;
  localparam int S_W      = 48;
  localparam int M_W      = 64;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam int ATAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t          cal_x;
    sample_t          cal_y;
    sample_t          cal_z;
    logic [DEG_W-1:0] heading;
  } fix_t;

  logic           clk;
  logic           rst;
  logic           s_tvalid;
  logic           s_tready;
  logic [S_W-1:0] s_tdata;   // mag_x, mag_y, mag_z
  logic           m_tvalid;
  logic           m_tready = 1'b1;
  logic [M_W-1:0] m_tdata;   // cal_x, cal_y, cal_z, heading_deg, zero pad

  // Calibration state mirrored from the block
  sample_t axis_max [3];
  sample_t axis_min [3];
  sample_t axis_off [3];

  fix_t expected_fixes[$];
  int   mismatch_count;
  bit   paced;
  int   ready_stall = 0;

  magnetometer_hard_iron_heading #(
    .SAMPLE_WIDTH      (SAMPLE_W),
    .CORDIC_ITERATIONS (CORDIC_N)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < 40) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Heading in whole degrees from corrected x and y, vectoring CORDIC
  function automatic logic [DEG_W-1:0] heading_of_fix(input longint x, input longint y);
    longint ax;
    longint ay;
    longint dx;
    longint dy;
    longint ang;
    longint t;
    longint d;
    if (x == 0) begin
      if (y > 0) return DEG_W'(90);
      if (y < 0) return DEG_W'(270);
      return DEG_W'(0);
    end
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    ang = 0;
    if (ay != 0) begin
      for (int i = 0; i < CORDIC_N && i < 24; i++) begin
        dx = ay >>> i;
        dy = ax >>> i;
        if (ay > 0) begin
          ax = ax + dx;
          ay = ay - dy;
          ang += ATAN_Q16[i];
        end else begin
          ax = ax - dx;
          ay = ay + dy;
          ang -= ATAN_Q16[i];
        end
      end
      if (ang < 0) ang = 0;
      if (ang > (longint'(90) << 16)) ang = longint'(90) << 16;
    end
    if (x > 0) t = (y >= 0) ? ang : (longint'(360) << 16) - ang;
    else       t = (y <= 0) ? (longint'(180) << 16) + ang : (longint'(180) << 16) - ang;
    d = t >>> 16;
    while (d >= 360) d -= 360;
    return DEG_W'(d);
  endfunction

  // Track extremes, update offsets and predict the corrected sample and heading
  function automatic fix_t calibrate_sample(input sample_t x, input sample_t y, input sample_t z);
    sample_t raw [3];
    sample_t cal [3];
    longint  sum;
    fix_t    f;
    raw[0] = x;
    raw[1] = y;
    raw[2] = z;
    for (int k = 0; k < 3; k++) begin
      if (axis_max[k] < raw[k]) begin
        axis_max[k] = raw[k];
        sum = longint'(axis_max[k]) + longint'(axis_min[k]);
        axis_off[k] = sample_t'(sum >>> 1);
      end else if (axis_min[k] > raw[k]) begin
        axis_min[k] = raw[k];
        sum = longint'(axis_max[k]) + longint'(axis_min[k]);
        axis_off[k] = sample_t'(sum >>> 1);
      end
      cal[k] = raw[k] - axis_off[k];
    end
    f.cal_x   = cal[0];
    f.cal_y   = cal[1];
    f.cal_z   = cal[2];
    f.heading = heading_of_fix(longint'(cal[0]), longint'(cal[1]));
    return f;
  endfunction

  // Drive one raw sample, wait for its transaction, queue the predicted fix
  task automatic push_sample(input sample_t x, input sample_t y, input sample_t z);
    int gap;
    gap = paced ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= S_W'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_fixes.push_back(calibrate_sample(x, y, z));
  endtask

  // Pick raw values that give the wanted corrected values under the current offsets
  task automatic push_corrected(input sample_t cx, input sample_t cy, input sample_t cz);
    push_sample(cx + axis_off[0], cy + axis_off[1], cz + axis_off[2]);
  endtask

  // Hold the sender until every queued fix has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_fixes.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    fix_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_fixes.size() == 0) begin
        flag_mismatch($sformatf("result with no sample pending, tdata %h", m_tdata));
      end else begin
        want = expected_fixes.pop_front();
        if (m_tdata[15:0] !== want.cal_x)
          flag_mismatch($sformatf("cal_x %0d, want %0d", $signed(m_tdata[15:0]), want.cal_x));
        if (m_tdata[31:16] !== want.cal_y)
          flag_mismatch($sformatf("cal_y %0d, want %0d", $signed(m_tdata[31:16]), want.cal_y));
        if (m_tdata[47:32] !== want.cal_z)
          flag_mismatch($sformatf("cal_z %0d, want %0d", $signed(m_tdata[47:32]), want.cal_z));
        if (m_tdata[56:48] !== want.heading)
          flag_mismatch($sformatf("heading %0d, want %0d (x %0d y %0d)", m_tdata[56:48],
                                  want.heading, want.cal_x, want.cal_y));
        if (m_tdata[63:57] !== '0)
          flag_mismatch($sformatf("pad bits %b not zero", m_tdata[63:57]));
      end
    end
    // Output back-pressure: when paced, a random stall after each transaction
    if (m_tvalid && m_tready) ready_stall = paced ? $urandom_range(0, 4) : 0;
    else if (ready_stall > 0) ready_stall--;
    m_tready <= (ready_stall == 0);
  end

  // New max, new min and equal-extreme samples from the reset state
  task automatic test_extreme_tracking();
    push_sample(0, 0, 0);
    push_sample(100, -50, 7);
    push_sample(100, -50, 7);
    push_sample(-60, 40, -9);
    push_sample(-60, 40, -9);
    push_sample(201, 201, 201);
    push_sample(-200, -200, -200);
  endtask

  // Every quadrant and the zero x / zero y headings
  task automatic test_quadrants();
    push_corrected(0, 5, 1);
    push_corrected(0, -5, -1);
    push_corrected(0, 0, 3);
    push_corrected(5, 0, -3);
    push_corrected(-5, 0, 0);
    push_corrected(7, 7, 2);
    push_corrected(-7, 7, -2);
    push_corrected(-7, -7, 9);
    push_corrected(7, -7, -9);
    push_corrected(150, -1, 0);
    push_corrected(-150, 1, 0);
  endtask

  // Range that widens slowly, so max/min/offset updates keep happening
  task automatic test_growing_range();
    sample_t v [3];
    int      bound;
    int      pick;
    for (int i = 0; i < 900; i++) begin
      if (i % 150 == 0) paced = (i % 300 == 0);
      bound = 40 + i * 37;
      if (bound > 32767) bound = 32767;
      for (int k = 0; k < 3; k++) begin
        pick = $urandom_range(0, 15);
        case (pick)
          0:       v[k] = axis_max[k];
          1:       v[k] = axis_min[k];
          2:       v[k] = axis_off[k];
          default: v[k] = sample_t'(int'($urandom_range(0, 2 * bound)) - bound);
        endcase
      end
      push_sample(v[0], v[1], v[2]);
    end
    paced = 1'b1;
  endtask

  // Full-scale samples and corrected values that wrap
  task automatic test_full_scale();
    push_sample(32767, 32767, 32767);
    push_sample(-32768, -32768, -32768);
    push_corrected(-32768, -32768, -32768);
    push_corrected(32767, 32767, 32767);
    push_corrected(32767, -1, 0);
    push_corrected(-32768, 1, 5);
    push_corrected(1, -32768, -32768);
    push_corrected(0, -32768, 32767);
  endtask

  // Uniform samples over the whole field range
  task automatic test_full_range_random();
    sample_t v [3];
    int      pick;
    for (int i = 0; i < 920; i++) begin
      if (i % 130 == 0) paced = (i % 260 != 0);
      for (int k = 0; k < 3; k++) begin
        pick = $urandom_range(0, 15);
        case (pick)
          0:       v[k] = axis_off[k];
          1:       v[k] = 16'sh7fff;
          2:       v[k] = 16'sh8000;
          default: v[k] = sample_t'($urandom);
        endcase
      end
      push_sample(v[0], v[1], v[2]);
    end
    paced = 1'b1;
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    mismatch_count = 0;
    paced          = 1'b1;
    for (int k = 0; k < 3; k++) begin
      axis_max[k] = '0;
      axis_min[k] = '0;
      axis_off[k] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extreme_tracking();
    wait_drained();
    test_quadrants();
    test_growing_range();
    wait_drained();
    test_full_scale();
    test_full_range_random();
    wait_drained();

    // Let any stray result show up
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_fixes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d fixes pending", expected_fixes.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
